[rtl/core/xpc_pkg.sv]
package xpc_pkg;

  localparam int CHUNK_BITS = 256;
  localparam int WORD_BITS  = 64;
  localparam int IN_WORDS   = 4;
  localparam int WORDS_RAW  = CHUNK_BITS / WORD_BITS;
  localparam int WORDS      = (WORDS_RAW < 1) ? 1 : ((WORDS_RAW > IN_WORDS) ? IN_WORDS : WORDS_RAW);
  localparam int USED_BITS  = WORDS * WORD_BITS;

  localparam int CNT_W  = $clog2(WORD_BITS + 1);
  localparam int CSUM_W = $clog2(USED_BITS + 1);

  localparam int SUM_W   = 21;
  localparam int SCALE_W = 20;
  localparam int RES_W   = 45;
  localparam int FRAC_W  = 16;

  localparam int IN_DATA_W  = ((2 * IN_WORDS * WORD_BITS + SCALE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SUM_W + RES_W + 7) / 8) * 8;

  localparam logic [SCALE_W-1:0] ALPHA_RESET = SCALE_W'(65536);

  typedef logic [WORD_BITS-1:0]    word_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [SCALE_W-1:0]      scale_t;
  typedef logic signed [RES_W-1:0] scaled_t;

  // Finished position handed from the accumulator to the scaling pipeline.
  typedef struct packed {
    sum_t   sum;
    logic   sat;
    scale_t k;
  } req_t;

  typedef struct packed {
    scaled_t scaled;
    sum_t    raw;
    logic    sat;
  } res_t;

endpackage

[rtl/core/xpc_lane.sv]
module xpc_lane (
  input  logic          clk,
  input  logic          en,
  input  xpc_pkg::word_t src,
  input  xpc_pkg::word_t weight,
  output xpc_pkg::cnt_t  cnt_r
);

  function automatic logic [3:0] byte_ones(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  xpc_pkg::word_t match;
  xpc_pkg::cnt_t  cnt_nxt;

  assign match = ~(src ^ weight);

  // Two-level count: ones per byte, then the byte counts added up.
  always_comb begin
    cnt_nxt = '0;
    for (int b = 0; b < xpc_pkg::WORD_BITS / 8; b++) begin
      cnt_nxt = cnt_nxt + xpc_pkg::CNT_W'(byte_ones(match[b*8 +: 8]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/core/xpc_merge.sv]
module xpc_merge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           in_inside,
  input  logic           in_last,
  input  xpc_pkg::scale_t in_k,
  input  xpc_pkg::cnt_t   counts [xpc_pkg::WORDS],
  input  logic           down_ready,
  output logic           up_ready,
  output logic           req_valid,
  output xpc_pkg::req_t   req
);

  localparam int CON_W = xpc_pkg::CSUM_W + 2;
  localparam int EXT_W = xpc_pkg::SUM_W + 2;
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((1 << (xpc_pkg::SUM_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] SAT_LO = -EXT_W'(1 << (xpc_pkg::SUM_W - 1));

  logic            s1_v_r;
  logic            s1_inside_r;
  logic            s1_last_r;
  xpc_pkg::scale_t s1_k_r;
  xpc_pkg::sum_t   running_r, running_nxt;
  logic            sat_r, sat_nxt;
  logic            s1_fire;

  logic [xpc_pkg::CSUM_W-1:0] cnt_sum;
  logic signed [CON_W-1:0]    contrib;
  logic signed [EXT_W-1:0]    wide;
  xpc_pkg::sum_t              new_sum;
  logic                       new_sat;

  assign s1_fire  = s1_v_r && (!s1_last_r || down_ready);
  assign up_ready = !s1_v_r || s1_fire;

  always_comb begin
    cnt_sum = '0;
    for (int i = 0; i < xpc_pkg::WORDS; i++) begin
      cnt_sum = cnt_sum + xpc_pkg::CSUM_W'(counts[i]);
    end
  end

  // Each matching bit counts +1, each mismatch -1: 2*ones - width.
  assign contrib = $signed({1'b0, cnt_sum, 1'b0}) - $signed(CON_W'(xpc_pkg::USED_BITS));
  assign wide    = {{2{running_r[xpc_pkg::SUM_W-1]}}, running_r}
                 + {{(EXT_W - CON_W){contrib[CON_W-1]}}, contrib};

  always_comb begin
    new_sum = running_r;
    new_sat = sat_r;
    if (s1_inside_r) begin
      if (wide > SAT_HI) begin
        new_sum = xpc_pkg::SUM_W'(SAT_HI);
        new_sat = 1'b1;
      end else if (wide < SAT_LO) begin
        new_sum = xpc_pkg::SUM_W'(SAT_LO);
        new_sat = 1'b1;
      end else begin
        new_sum = xpc_pkg::SUM_W'(wide);
      end
    end
  end

  always_comb begin
    running_nxt = running_r;
    sat_nxt     = sat_r;
    if (s1_fire) begin
      if (s1_last_r) begin
        running_nxt = '0;
        sat_nxt     = 1'b0;
      end else begin
        running_nxt = new_sum;
        sat_nxt     = new_sat;
      end
    end
  end

  assign req_valid = s1_v_r && s1_last_r;
  assign req.sum   = new_sum;
  assign req.sat   = new_sat;
  assign req.k     = s1_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      running_r <= '0;
      sat_r     <= 1'b0;
    end else begin
      running_r <= running_nxt;
      sat_r     <= sat_nxt;
      if (up_ready) begin
        s1_v_r <= in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_inside_r <= in_inside;
      s1_last_r   <= in_last;
      s1_k_r      <= in_k;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (running_r == '0 && !sat_r))
    else $error("accumulator not cleared after a finished position");

  a_padding_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_inside_r && !s1_last_r) |=> (running_r == $past(running_r)))
    else $error("padding chunk changed the running sum");

  a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_last_r && !down_ready) |-> !up_ready)
    else $error("input taken while a finished position is blocked");

endmodule

[rtl/core/xpc_scale.sv]
module xpc_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  xpc_pkg::scale_t alpha,
  input  logic            req_valid,
  input  xpc_pkg::req_t   req,
  output logic            req_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output xpc_pkg::res_t   res
);

  localparam int P1_W = xpc_pkg::SUM_W + xpc_pkg::SCALE_W;
  localparam int LO_W = xpc_pkg::SCALE_W + 1;
  localparam int HI_W = P1_W - LO_W;
  localparam int PH_W = HI_W + xpc_pkg::SCALE_W + 1;
  localparam int PL_W = LO_W + xpc_pkg::SCALE_W;
  localparam int PW   = PH_W + LO_W;
  localparam logic [PW-1:0] ROUND = PW'(1) << (xpc_pkg::FRAC_W - 1);

  logic va_r, vb_r, vc_r, vo_r;
  logic ld_a, ld_b, ld_c, ld_o;

  xpc_pkg::sum_t   a_sum_r;
  logic            a_sat_r;
  xpc_pkg::scale_t a_k_r;

  logic signed [P1_W-1:0] b_p1_r;
  xpc_pkg::sum_t          b_raw_r;
  logic                   b_sat_r;
  xpc_pkg::scale_t        b_k_r;

  logic signed [PH_W-1:0] c_hi_r;
  logic [PL_W-1:0]        c_lo_r;
  xpc_pkg::sum_t          c_raw_r;
  logic                   c_sat_r;

  xpc_pkg::res_t o_res_r;

  logic signed [P1_W:0]   p1_full;
  logic signed [PH_W-1:0] hi_prod;
  logic [PL_W-1:0]        lo_prod;
  logic [PW-1:0]          total;

  assign ld_o      = !vo_r || out_ready;
  assign ld_c      = !vc_r || ld_o;
  assign ld_b      = !vb_r || ld_c;
  assign ld_a      = !va_r || ld_b;
  assign req_ready = ld_a;

  assign p1_full = $signed(a_sum_r) * $signed({1'b0, alpha});
  // The wide product times k is split into a signed high and an unsigned low part.
  assign hi_prod = $signed(b_p1_r[P1_W-1:LO_W]) * $signed({1'b0, b_k_r});
  assign lo_prod = b_p1_r[LO_W-1:0] * b_k_r;
  assign total   = {c_hi_r, {LO_W{1'b0}}} + PW'(c_lo_r) + ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld_a) va_r <= req_valid;
      if (ld_b) vb_r <= va_r;
      if (ld_c) vc_r <= vb_r;
      if (ld_o) vo_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_sum_r <= req.sum;
      a_sat_r <= req.sat;
      a_k_r   <= req.k;
    end
    if (ld_b) begin
      b_p1_r  <= p1_full[P1_W-1:0];
      b_raw_r <= a_sum_r;
      b_sat_r <= a_sat_r;
      b_k_r   <= a_k_r;
    end
    if (ld_c) begin
      c_hi_r  <= hi_prod;
      c_lo_r  <= lo_prod;
      c_raw_r <= b_raw_r;
      c_sat_r <= b_sat_r;
    end
    if (ld_o) begin
      o_res_r.scaled <= total[xpc_pkg::RES_W + xpc_pkg::FRAC_W - 1:xpc_pkg::FRAC_W];
      o_res_r.raw    <= c_raw_r;
      o_res_r.sat    <= c_sat_r;
    end
  end

  assign out_valid = vo_r;
  assign res       = o_res_r;

endmodule

[rtl/core/xnor_popcount_conv_accumulator_core.sv]
// After its last chunk is taken, a result passes scale registers a, b, c and the output register.
// Throughput: one chunk per cycle, set by the merge accumulate loop, unless a last chunk stalls;
// finished positions leave at one per cycle through the multiplier pipeline with out_tready high.
// Reset (rst_n low at a clock edge, synchronous): the running sum and saturation flag clear,
// alpha returns to 1.0 (Q4.16), and every pipeline stage and the output are emptied.
module xnor_popcount_conv_accumulator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // From bit 0 up: src_word0..3, weight_word0..3, position_scale, zero fill.
  input  logic [xpc_pkg::IN_DATA_W-1:0]   in_tdata,
  // tap_inside.
  input  logic                            in_tuser,
  // last_chunk.
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // From bit 0 up: raw_sum, scaled_result, zero fill.
  output logic [xpc_pkg::OUT_DATA_W-1:0]  out_tdata,
  // sum_saturated.
  output logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [xpc_pkg::SCALE_W-1:0]     cfg_wdata
);

  localparam int W = xpc_pkg::WORD_BITS;
  localparam int K_LSB = 2 * xpc_pkg::IN_WORDS * W;

  // Layer scale alpha; software must write it only while the block is idle (not enforced here).
  xpc_pkg::scale_t alpha_r;

  logic          in_fire;
  xpc_pkg::cnt_t counts [xpc_pkg::WORDS];
  logic          req_valid, req_ready;
  xpc_pkg::req_t req;
  xpc_pkg::res_t res;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= xpc_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      alpha_r <= cfg_wdata;
    end
  end

  // One lane per 64-bit word of the chunk. Each lane matches its source and weight
  // word and registers the count of agreeing bits; words beyond the configured
  // chunk width get no lane and are ignored.
  for (genvar g = 0; g < xpc_pkg::WORDS; g++) begin : g_lane
    xpc_lane u_lane (
      .clk    (clk),
      .en     (in_fire),
      .src    (in_tdata[g*W +: W]),
      .weight (in_tdata[(xpc_pkg::IN_WORDS + g)*W +: W]),
      .cnt_r  (counts[g])
    );
  end

  // The merge stage folds the lane counts into the saturating running sum. A chunk
  // that does not end a position never waits; the last chunk of a position waits
  // only when the scaling pipeline is full.
  xpc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_inside  (in_tuser),
    .in_last    (in_tlast),
    .in_k       (in_tdata[K_LSB +: xpc_pkg::SCALE_W]),
    .counts     (counts),
    .down_ready (req_ready),
    .up_ready   (in_tready),
    .req_valid  (req_valid),
    .req        (req)
  );

  // The scaling pipeline multiplies the sum by alpha, then by k in two partial
  // products, rounds half up to Q.16, and holds the result in an output register.
  xpc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .alpha     (alpha_r),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {{(xpc_pkg::OUT_DATA_W - xpc_pkg::SUM_W - xpc_pkg::RES_W){1'b0}},
                      res.scaled, res.raw};
  assign out_tuser = res.sat;

endmodule
